@@ hdl/lvs_pkg.sv @@
// Shared types, constants and coefficient tables for the Legendre value and slope block.
`default_nettype none
package lvs_pkg;

    localparam int MAX_ORDER_LIMIT = 15;
    localparam int FRAC_BITS = 20;
    localparam int ORD_W = $clog2(MAX_ORDER_LIMIT + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef logic [31:0] t_ctab [0:MAX_ORDER_LIMIT];

    typedef struct packed {
        logic signed [15:0] x;
        logic [ORD_W-1:0]   top;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    typedef enum logic [3:0] {
        STEP_XP  = 4'd0,
        STEP_AP  = 4'd1,
        STEP_XD  = 4'd2,
        STEP_AD  = 4'd3,
        STEP_PLO = 4'd4,
        STEP_PHI = 4'd5,
        STEP_DLO = 4'd6,
        STEP_DHI = 4'd7,
        STEP_ACC = 4'd8,
        STEP_OUT = 4'd9
    } t_step;

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = val;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = 65'd0;
        quo = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic t_ctab build_a();
        t_ctab t;
        logic [63:0] k;
        t[0] = 32'd0;
        for (int i = 1; i <= MAX_ORDER_LIMIT; i++) begin
            k = 64'(i);
            t[i] = 32'(isqrt64((64'd1 << 58) + udiv64(64'd1 << 58, 64'd4 * k * k - 64'd1)));
        end
        return t;
    endfunction

    function automatic t_ctab build_r();
        t_ctab t;
        logic [63:0] k;
        t[0] = 32'd0;
        for (int i = 1; i <= MAX_ORDER_LIMIT; i++) begin
            k = 64'(i);
            t[i] = 32'(isqrt64((64'd1 << 62) - udiv64(64'd1 << 60, k * k)));
        end
        return t;
    endfunction

    localparam t_ctab A_TAB = build_a();
    localparam t_ctab R_TAB = build_r();
    localparam logic [63:0] SQ32 = isqrt64(64'd3 << 59);
    localparam logic [63:0] RSQ2 = isqrt64(64'd1 << 59);
    localparam logic [31:0] P0_VAL =
        32'((RSQ2 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    localparam logic [31:0] D1_VAL =
        32'((SQ32 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));

    function automatic logic signed [31:0] sat32(input logic neg, input logic [63:0] mag);
        logic signed [31:0] res;
        if (neg) begin
            if (mag >= (64'd1 << 31)) begin
                res = 32'sh8000_0000;
            end else begin
                res = -$signed(mag[31:0]);
            end
        end else begin
            if (mag > 64'h7FFF_FFFF) begin
                res = 32'sh7FFF_FFFF;
            end else begin
                res = $signed(mag[31:0]);
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ hdl/legendre_value_and_slope.sv @@
// Top level of the orthonormal Legendre value and slope generator.
//
// A sample point x (signed Q2.14) is offered on i_x_sample with start; it is
// taken at a clock edge where start is high and busy is low. Up to two points
// wait in a queue while the engine works, and busy is high only when it is full.
// For each point the block emits one item per order 0 .. max_order, in rising
// order, each on the result ports for a single cycle with o_result_valid high;
// o_run_end marks the item of the highest order. The receiver cannot stall.
// Order 0 needs no product; order 1 and every higher order are worked out on
// the single shared 33 x 33 multiplier that every product passes through. A
// point is written into the queue, taken from it by the idle engine, and its
// first item then leaves through the output registers. max_order is written
// over the APB port at byte address 0 and resets to 1. Reset empties the queue
// and idles the engine; no item is in flight afterwards.
`default_nettype none
module legendre_value_and_slope (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic signed [15:0]   i_x_sample,
    output logic                      o_result_valid,
    output logic [3:0]                o_order_index,
    output logic signed [31:0]        o_poly_value,
    output logic signed [31:0]        o_poly_slope,
    output logic                      o_run_end,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import lvs_pkg::*;

    localparam logic ADDR_MAX_ORDER = 1'b0;

    logic [3:0]  r_max_order;
    logic        w_push;
    logic        w_full;
    logic        w_avail;
    logic        w_pop;
    t_job        w_job;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_MAX_ORDER) ? {28'd0, r_max_order} : 32'd0;
    assign busy   = w_full;
    assign w_push = start && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_order <= 4'd1;
        end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_MAX_ORDER) begin
            r_max_order <= pwdata[3:0];
        end
    end

    lvs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_x         (i_x_sample),
        .i_max_order (r_max_order),
        .o_full      (w_full),
        .o_avail     (w_avail),
        .i_pop       (w_pop),
        .o_job       (w_job)
    );

    lvs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (w_avail),
        .i_job         (w_job),
        .o_pop         (w_pop),
        .o_valid       (o_result_valid),
        .o_order_index (o_order_index),
        .o_poly_value  (o_poly_value),
        .o_poly_slope  (o_poly_slope),
        .o_run_end     (o_run_end)
    );

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_result_valid)
        else $error("Result strobe raised straight after reset.");

    a_run_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_run_end |=> !o_result_valid)
        else $error("Next run started without the engine leaving the run.");

    a_order_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_run_end |-> o_order_index != 4'd15)
        else $error("Run continued past the highest order.");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_avail)
        else $error("Engine took a point from an empty queue.");

endmodule
`default_nettype wire

@@ hdl/lvs_front.sv @@
// Front end: takes sample points, clamps the order range and queues them for the engine.
`default_nettype none
module lvs_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire logic signed [15:0]   i_x,
    input  wire logic [3:0]           i_max_order,
    output logic                      o_full,
    output logic                      o_avail,
    input  wire logic                 i_pop,
    output lvs_pkg::t_job             o_job
);
    import lvs_pkg::*;

    t_job                r_mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QPTR_W:0]     r_cnt;
    t_job                w_job;

    always_comb begin
        w_job.x = i_x;
        if (32'(i_max_order) > MAX_ORDER_LIMIT) begin
            w_job.top = ORD_W'(MAX_ORDER_LIMIT);
        end else begin
            w_job.top = ORD_W'(i_max_order);
        end
    end

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/lvs_back.sv @@
// Back end: runs the three-term recurrence on one shared multiplier and emits one item per order.
`default_nettype none
module lvs_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_avail,
    input  lvs_pkg::t_job             i_job,
    output logic                      o_pop,
    output logic                      o_valid,
    output logic [3:0]                o_order_index,
    output logic signed [31:0]        o_poly_value,
    output logic signed [31:0]        o_poly_slope,
    output logic                      o_run_end
);
    import lvs_pkg::*;

    t_state               r_state;
    logic [3:0]           r_step;
    logic [ORD_W-1:0]     r_n;
    logic [ORD_W-1:0]     r_top;
    logic signed [15:0]   r_x;
    logic signed [31:0]   r_pv1, r_pv2, r_dv1, r_dv2, r_pvn;
    logic signed [65:0]   r_prod;
    logic [63:0]          r_acc;
    logic [34:0]          r_m;
    logic [65:0]          r_q;
    logic                 r_negp, r_negd;
    logic                 r_ovalid, r_oend;
    logic [3:0]           r_oord;
    logic signed [31:0]   r_opv, r_odv;

    logic signed [32:0]   w_opa, w_opb;
    logic [ORD_W-1:0]     w_km1;
    logic [63:0]          w_amag;
    logic [64:0]          w_around;
    logic [65:0]          w_pmag;
    logic [65:0]          w_q30;
    logic [65:0]          w_p24;
    logic signed [31:0]   w_qsat_d, w_pv_n1;
    logic                 w_last;

    assign w_km1 = r_n - 1'b1;
    assign w_last = (r_n == r_top);
    assign o_pop = (r_state == ST_IDLE) && i_avail;

    always_comb begin
        w_opa = 33'sd0;
        w_opb = 33'sd0;
        if (r_n == ORD_W'(1)) begin
            w_opa = 33'(r_x);
            w_opb = $signed({1'b0, SQ32[31:0]});
        end else begin
            case (r_step)
                STEP_XP: begin
                    w_opa = 33'(r_x);
                    w_opb = 33'(r_pv1);
                end
                STEP_AP: begin
                    w_opa = $signed({1'b0, A_TAB[w_km1]});
                    w_opb = 33'(r_pv2);
                end
                STEP_XD: begin
                    w_opa = 33'(r_x);
                    w_opb = 33'(r_dv1);
                end
                STEP_AD: begin
                    w_opa = $signed({1'b0, A_TAB[w_km1]});
                    w_opb = 33'(r_dv2);
                end
                STEP_PLO, STEP_DLO: begin
                    w_opa = $signed({16'd0, r_m[16:0]});
                    w_opb = $signed({1'b0, R_TAB[r_n]});
                end
                STEP_PHI, STEP_DHI: begin
                    w_opa = $signed({15'd0, r_m[34:17]});
                    w_opb = $signed({1'b0, R_TAB[r_n]});
                end
                default: begin
                    w_opa = 33'sd0;
                    w_opb = 33'sd0;
                end
            endcase
        end
    end

    always_comb begin
        w_amag   = r_acc[63] ? (64'd0 - r_acc) : r_acc;
        w_around = {1'b0, w_amag} + (65'd1 << 29);
        w_pmag   = r_prod[65] ? (66'd0 - r_prod) : r_prod;
        w_p24    = (w_pmag + (66'd1 << (43 - FRAC_BITS))) >> (44 - FRAC_BITS);
        w_q30    = (r_q + (66'd1 << 29)) >> 30;
        w_qsat_d = sat32(r_negd, w_q30[63:0]);
        w_pv_n1  = sat32(r_prod[65], w_p24[63:0]);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_opa * w_opb;
        if (o_pop) begin
            r_x   <= i_job.x;
            r_top <= i_job.top;
        end
        if (r_state == ST_RUN && r_n > ORD_W'(1)) begin
            case (r_step)
                STEP_AP: begin
                    r_acc <= {r_prod[47:0], 16'd0};
                end
                STEP_XD: begin
                    r_acc <= r_acc - r_prod[63:0];
                end
                STEP_AD: begin
                    r_m    <= w_around[64:30];
                    r_negp <= r_acc[63];
                    r_acc  <= {r_pv1[31], r_pv1[31], r_pv1, 30'd0} + {r_prod[47:0], 16'd0};
                end
                STEP_PLO: begin
                    r_acc <= r_acc - r_prod[63:0];
                end
                STEP_PHI: begin
                    r_m    <= w_around[64:30];
                    r_negd <= r_acc[63];
                    r_q    <= r_prod;
                end
                STEP_DLO: begin
                    r_q <= r_q + {r_prod[48:0], 17'd0};
                end
                STEP_DHI: begin
                    r_pvn <= sat32(r_negp, w_q30[63:0]);
                    r_q   <= r_prod;
                end
                STEP_ACC: begin
                    r_q <= r_q + {r_prod[48:0], 17'd0};
                end
                default: begin
                    r_q <= r_q;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_n      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_avail) begin
                        r_state <= ST_RUN;
                        r_n     <= '0;
                        r_step  <= '0;
                    end
                end
                ST_RUN: begin
                    r_step <= r_step + 1'b1;
                    if (r_n == '0) begin
                        r_ovalid <= 1'b1;
                        r_opv    <= $signed(P0_VAL);
                        r_odv    <= 32'sd0;
                        r_pv1    <= $signed(P0_VAL);
                        r_dv1    <= 32'sd0;
                        r_step   <= '0;
                        r_n      <= r_n + 1'b1;
                    end else if (r_n == ORD_W'(1)) begin
                        if (r_step == STEP_AP) begin
                            r_ovalid <= 1'b1;
                            r_opv    <= w_pv_n1;
                            r_odv    <= $signed(D1_VAL);
                            r_pv2    <= r_pv1;
                            r_pv1    <= w_pv_n1;
                            r_dv2    <= r_dv1;
                            r_dv1    <= $signed(D1_VAL);
                            r_step   <= '0;
                            r_n      <= r_n + 1'b1;
                        end
                    end else if (r_step == STEP_OUT) begin
                        r_ovalid <= 1'b1;
                        r_opv    <= r_pvn;
                        r_odv    <= w_qsat_d;
                        r_pv2    <= r_pv1;
                        r_pv1    <= r_pvn;
                        r_dv2    <= r_dv1;
                        r_dv1    <= w_qsat_d;
                        r_step   <= '0;
                        r_n      <= r_n + 1'b1;
                    end
                    if (((r_n == '0) || (r_n == ORD_W'(1) && r_step == STEP_AP)
                            || (r_n > ORD_W'(1) && r_step == STEP_OUT)) && w_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN) begin
            r_oord <= 4'(r_n);
            r_oend <= w_last;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_order_index = r_oord;
    assign o_poly_value  = r_opv;
    assign o_poly_slope  = r_odv;
    assign o_run_end     = r_oend;

endmodule
`default_nettype wire
